FILE: sv/sefp_pkg.sv
// ----------------------------------------------------------------------------
// sefp_pkg
// shared constants, parser phases and the beat structs passed between
// the parser, the payload memory and the readout sequencer
// ----------------------------------------------------------------------------
package sefp_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 5;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_CMD   = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CHECK = 3'd4,
		PH_END   = 3'd5
	} phase_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} sefp_wr_t;

	typedef struct packed {
		logic              go;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
	} sefp_launch_t;

endpackage

FILE: sv/sefp_ram.sv
// ----------------------------------------------------------------------------
// sefp_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sefp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/sefp_parser.sv
// ----------------------------------------------------------------------------
// sefp_parser
// byte-level frame state machine: tracks phase, command, length and xor
// check, writes payload bytes into the payload ram and launches readout
// ----------------------------------------------------------------------------
module sefp_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            beat,
	input  logic [sefp_pkg::BYTE_W-1:0]     rx_byte,
	input  logic [sefp_pkg::BYTE_W-1:0]     start_byte,
	input  logic [sefp_pkg::BYTE_W-1:0]     end_byte,
	output sefp_pkg::sefp_wr_t              wr,
	output sefp_pkg::sefp_launch_t          launch
);
	import sefp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  cmd_q, cmd_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   fill_q, fill_d;
	logic [BYTE_W-1:0]  chk_q, chk_d;
	logic [LEN_W-1:0]   fill_inc;
	phase_t             drop_phase;

	assign fill_inc   = fill_q + LEN_W'(1);
	assign drop_phase = (rx_byte == start_byte) ? PH_CMD : PH_WAIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cmd_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			chk_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			chk_q   <= chk_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		fill_d     = fill_q;
		chk_d      = chk_q;
		wr.en      = 1'b0;
		wr.addr    = fill_q[ADDR_W-1:0];
		wr.data    = rx_byte;
		launch.go  = 1'b0;
		launch.cmd = cmd_q;
		launch.len = len_q;
		if (beat) begin
			case (phase_q)
				PH_WAIT: begin
					if (rx_byte == start_byte) begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
						phase_d = PH_WAIT;
					end else begin
						len_d   = rx_byte[LEN_W-1:0];
						fill_d  = '0;
						chk_d   = start_byte ^ cmd_q ^ rx_byte;
						phase_d = (rx_byte != '0) ? PH_DATA : PH_CHECK;
					end
				end
				PH_DATA: begin
					wr.en  = 1'b1;
					chk_d  = chk_q ^ rx_byte;
					fill_d = fill_inc;
					if (fill_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (rx_byte != chk_q) begin
						phase_d = drop_phase;
					end else begin
						phase_d = PH_END;
					end
				end
				PH_END: begin
					if (rx_byte != end_byte) begin
						phase_d = drop_phase;
					end else begin
						phase_d   = PH_WAIT;
						launch.go = 1'b1;
					end
				end
				default: begin
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

endmodule

FILE: sv/sefp_readout.sv
// ----------------------------------------------------------------------------
// sefp_readout
// walks the payload ram after a good frame, one read in flight at a time,
// and loads each result into the output register
// ----------------------------------------------------------------------------
module sefp_readout (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sefp_pkg::sefp_launch_t              launch,
	input  logic [sefp_pkg::BYTE_W-1:0]         rdata,
	output logic [sefp_pkg::ADDR_W-1:0]         raddr,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sefp_pkg::BYTE_W-1:0]         command_code,
	output logic [sefp_pkg::LEN_W-1:0]          payload_len,
	output logic [sefp_pkg::IDX_W-1:0]          byte_index,
	output logic [sefp_pkg::BYTE_W-1:0]         payload_byte,
	output logic                                last
);
	import sefp_pkg::*;

	logic               busy_q;
	logic               pend_q;
	logic               out_valid_q;
	logic [LEN_W-1:0]   rd_idx_q;
	logic [BYTE_W-1:0]  cmd_q;
	logic [LEN_W-1:0]   len_q;
	logic [ADDR_W-1:0]  idx_s1;
	logic               last_s1;
	logic               zero_s1;
	logic [BYTE_W-1:0]  cmd_out_q;
	logic [LEN_W-1:0]   len_out_q;
	logic [IDX_W-1:0]   idx_out_q;
	logic [BYTE_W-1:0]  byte_out_q;
	logic               last_out_q;
	logic               issue;
	logic               last_issue;

	assign issue      = busy_q && !pend_q && (!out_valid_q || !out_stall);
	assign last_issue = (len_q == '0) || ((rd_idx_q + LEN_W'(1)) == len_q);
	assign raddr      = rd_idx_q[ADDR_W-1:0];
	assign busy       = busy_q || pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			pend_q <= issue;
			if (launch.go) begin
				busy_q   <= 1'b1;
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + LEN_W'(1);
				if (last_issue) begin
					busy_q <= 1'b0;
				end
			end
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch.go) begin
			cmd_q <= launch.cmd;
			len_q <= launch.len;
		end
		if (issue) begin
			idx_s1  <= rd_idx_q[ADDR_W-1:0];
			last_s1 <= last_issue;
			zero_s1 <= (len_q == '0);
		end
		if (pend_q) begin
			cmd_out_q  <= cmd_q;
			len_out_q  <= len_q;
			idx_out_q  <= IDX_W'(idx_s1);
			byte_out_q <= zero_s1 ? '0 : rdata;
			last_out_q <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = cmd_out_q;
	assign payload_len  = len_out_q;
	assign byte_index   = idx_out_q;
	assign payload_byte = byte_out_q;
	assign last         = last_out_q;

`ifndef SYNTHESIS
	a_pend_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !out_valid_q)
		else $error("read data returned while output register still holds a beat");

	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		launch.go |-> (!busy_q && !pend_q))
		else $error("frame launched while readout still active");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rd_idx_q <= len_q))
		else $error("read index ran past frame length");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_issue && !launch.go) |=> !busy_q)
		else $error("readout stayed busy after final read");
`endif

endmodule

FILE: sv/stx_etx_frame_parser.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_parser
// result path: a good end byte sets busy, reads are issued from busy, and each
//   result passes the ram read register and then the output register
// throughput: one byte per cycle while parsing; after a good end byte input
//   is stalled while the payload beats are read out, one read in flight at a time
// reset: start/end bytes return to 0x02/0x03, parser waits for a start byte,
//   payload ram is not cleared
// ----------------------------------------------------------------------------
module stx_etx_frame_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sefp_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sefp_pkg::BYTE_W-1:0]         command_code,
	output logic [sefp_pkg::LEN_W-1:0]          payload_len,
	output logic [sefp_pkg::IDX_W-1:0]          byte_index,
	output logic [sefp_pkg::BYTE_W-1:0]         payload_byte,
	output logic                                last
);
	import sefp_pkg::*;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	logic [BYTE_W-1:0]  start_byte_q;
	logic [BYTE_W-1:0]  end_byte_q;
	logic               cfg_wr;
	logic               beat;
	logic               busy;
	sefp_wr_t           wr;
	sefp_launch_t       launch;
	logic [ADDR_W-1:0]  raddr;
	logic [BYTE_W-1:0]  rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'h02;
			end_byte_q   <= 8'h03;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_START: start_byte_q <= pwdata[BYTE_W-1:0];
				REG_END:   end_byte_q   <= pwdata[BYTE_W-1:0];
				default:   start_byte_q <= start_byte_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START: prdata = {24'd0, start_byte_q};
			REG_END:   prdata = {24'd0, end_byte_q};
			default:   prdata = '0;
		endcase
	end

	assign in_stall = busy;
	assign beat     = in_valid && !in_stall;

	sefp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.rx_byte    (rx_byte),
		.start_byte (start_byte_q),
		.end_byte   (end_byte_q),
		.wr         (wr),
		.launch     (launch)
	);

	sefp_ram #(
		.DEPTH (MAX_PAYLOAD),
		.WIDTH (BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	sefp_readout u_readout (
		.clk          (clk),
		.arst_n       (arst_n),
		.launch       (launch),
		.rdata        (rdata),
		.raddr        (raddr),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code),
		.payload_len  (payload_len),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last)
	);

endmodule

FILE: verif/stx_etx_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_parser_tb
// Drives received bytes into the frame parser and checks every payload beat
// it emits against an in-bench parser model. Directed frames cover empty and
// full-size payloads, oversized lengths, bad checksum and end bytes with and
// without resync, register extremes and register changes inside a frame.
// Random frames with random register settings follow. The output sees random
// stall bursts and the input random idle gaps, except in the final stretch.
// ----------------------------------------------------------------------------
module stx_etx_frame_parser_tb;

	import sefp_pkg::*;

	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_END   = 3'd4;

	typedef enum {
		FLAW_NONE,
		FLAW_CHECK,
		FLAW_END,
		FLAW_CHECK_RESYNC,
		FLAW_END_RESYNC
	} flaw_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic              fin;
	} payload_beat_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] command_code;
	logic [LEN_W-1:0]  payload_len;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] payload_byte;
	logic              last;

	// parser model state
	phase_t            rx_phase = PH_WAIT;
	logic [BYTE_W-1:0] held_cmd = '0;
	logic [LEN_W-1:0]  held_len = '0;
	logic [LEN_W-1:0]  fill_idx = '0;
	logic [BYTE_W-1:0] run_chk = '0;
	logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
	logic [BYTE_W-1:0] cfg_start = 8'h02;
	logic [BYTE_W-1:0] cfg_end = 8'h03;

	payload_beat_t pending_beats [$];
	int            errors = 0;
	int            bytes_taken = 0;
	int            beats_seen = 0;
	bit            calm = 1'b0;
	int            stall_run = 0;

	stx_etx_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code),
		.payload_len  (payload_len),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic void drop_or_resync(input logic [BYTE_W-1:0] b);
		rx_phase = (b == cfg_start) ? PH_CMD : PH_WAIT;
	endfunction

	function automatic void parse_rx(input logic [BYTE_W-1:0] b);
		case (rx_phase)
			PH_WAIT: begin
				if (b == cfg_start)
					rx_phase = PH_CMD;
			end
			PH_CMD: begin
				held_cmd = b;
				rx_phase = PH_LEN;
			end
			PH_LEN: begin
				if (b > MAX_PAYLOAD) begin
					rx_phase = PH_WAIT;
				end else begin
					held_len = b[LEN_W-1:0];
					fill_idx = '0;
					run_chk = cfg_start ^ held_cmd ^ b;
					rx_phase = (b != 0) ? PH_DATA : PH_CHECK;
				end
			end
			PH_DATA: begin
				payload_mem[fill_idx] = b;
				run_chk = run_chk ^ b;
				fill_idx = fill_idx + 1'b1;
				if (fill_idx >= held_len)
					rx_phase = PH_CHECK;
			end
			PH_CHECK: begin
				if (b != run_chk)
					drop_or_resync(b);
				else
					rx_phase = PH_END;
			end
			PH_END: begin
				if (b != cfg_end) begin
					drop_or_resync(b);
				end else begin
					rx_phase = PH_WAIT;
					if (held_len == 0) begin
						pending_beats.push_back('{held_cmd, '0, '0, '0, 1'b1});
					end else begin
						for (int i = 0; i < held_len; i++)
							pending_beats.push_back('{held_cmd, held_len, IDX_W'(i),
								payload_mem[i], 1'(i + 1 == held_len)});
					end
				end
			end
			default: rx_phase = PH_WAIT;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// beat checker and input tracker
	always @(posedge clk) begin
		payload_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (pending_beats.size() == 0) begin
					$error("payload beat with nothing expected");
					errors++;
				end else begin
					want = pending_beats.pop_front();
					check_field("command_code", 32'(want.cmd), 32'(command_code));
					check_field("payload_len", 32'(want.len), 32'(payload_len));
					check_field("byte_index", 32'(want.idx), 32'(byte_index));
					check_field("payload_byte", 32'(want.data), 32'(payload_byte));
					check_field("last", 32'(want.fin), 32'(last));
				end
			end
			if (in_valid && !in_stall) begin
				bytes_taken++;
				parse_rx(rx_byte);
			end
		end
	end

	// output stall bursts
	always @(negedge clk) begin
		if (calm) begin
			out_stall = 1'b0;
		end else if (stall_run == 0) begin
			out_stall = ($urandom_range(0, 2) == 0);
			stall_run = out_stall ? $urandom_range(1, 8) : $urandom_range(1, 20);
		end else begin
			stall_run--;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input int len, input int fill,
		input flaw_t flaw, input bit with_start);
		logic [BYTE_W-1:0] chk;
		logic [BYTE_W-1:0] pb;
		chk = cfg_start ^ cmd ^ len[7:0];
		if (with_start)
			send_byte(cfg_start);
		send_byte(cmd);
		send_byte(len[7:0]);
		if (len > MAX_PAYLOAD)
			return;
		for (int i = 0; i < len; i++) begin
			pb = (fill < 0) ? 8'($urandom) : fill[7:0];
			chk = chk ^ pb;
			send_byte(pb);
		end
		if (flaw == FLAW_CHECK) begin
			send_byte(chk ^ 8'($urandom_range(1, 255)));
		end else if (flaw == FLAW_CHECK_RESYNC) begin
			send_byte(cfg_start);
		end else begin
			send_byte(chk);
			if (flaw == FLAW_END)
				send_byte(cfg_end ^ 8'($urandom_range(1, 255)));
			else if (flaw == FLAW_END_RESYNC)
				send_byte(cfg_start);
			else
				send_byte(cfg_end);
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = {24'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == REG_START)
			cfg_start = value;
		else if (addr == REG_END)
			cfg_end = value;
	endtask

	task automatic read_reg(input logic [2:0] addr, input logic [7:0] want);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		check_field("prdata", {24'd0, want}, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// wait for all beats out, then let the readout drain
	task automatic settle();
		while (pending_beats.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic test_registers();
		read_reg(REG_START, 8'h02);
		read_reg(REG_END, 8'h03);
		write_reg(REG_START, 8'hFF);
		write_reg(REG_END, 8'h00);
		read_reg(REG_START, 8'hFF);
		read_reg(REG_END, 8'h00);
		write_reg(REG_START, 8'h02);
		write_reg(REG_END, 8'h03);
		read_reg(REG_START, 8'h02);
		read_reg(REG_END, 8'h03);
	endtask

	task automatic test_frame_shapes();
		send_frame(8'h00, 0, -1, FLAW_NONE, 1'b1);
		send_frame(8'hFF, 1, 8'hFF, FLAW_NONE, 1'b1);
		send_frame(8'h5A, MAX_PAYLOAD, 8'hFF, FLAW_NONE, 1'b1);
		send_frame(8'hA5, 3, 8'h00, FLAW_NONE, 1'b1);
		send_frame(8'h11, MAX_PAYLOAD + 1, -1, FLAW_NONE, 1'b1);
		send_frame(8'h22, 255, -1, FLAW_NONE, 1'b1);
		send_frame(8'h23, 2, -1, FLAW_NONE, 1'b1);
	endtask

	task automatic test_bad_frames();
		send_frame(8'h33, 2, 8'h10, FLAW_CHECK, 1'b1);
		send_frame(8'h44, 2, 8'h10, FLAW_END, 1'b1);
		send_frame(8'h55, 1, 8'h10, FLAW_CHECK_RESYNC, 1'b1);
		send_frame(8'h56, 2, -1, FLAW_NONE, 1'b0);
		send_frame(8'h66, 0, -1, FLAW_END_RESYNC, 1'b1);
		send_frame(8'h67, 1, -1, FLAW_NONE, 1'b0);
	endtask

	task automatic test_register_extremes();
		settle();
		write_reg(REG_START, 8'h00);
		write_reg(REG_END, 8'hFF);
		send_frame(8'h00, 4, -1, FLAW_NONE, 1'b1);
		send_frame(8'hFF, 0, -1, FLAW_NONE, 1'b1);
		settle();
		write_reg(REG_START, 8'hFF);
		write_reg(REG_END, 8'h00);
		// oversized length equal to the start byte must not reopen a frame
		send_frame(8'h01, 255, -1, FLAW_NONE, 1'b1);
		send_byte(8'h10);
		send_frame(8'h02, 2, -1, FLAW_NONE, 1'b1);
		settle();
		write_reg(REG_START, 8'h7E);
		write_reg(REG_END, 8'h7E);
		send_frame(8'h7E, 2, 8'h7E, FLAW_NONE, 1'b1);
		settle();
		write_reg(REG_START, 8'h02);
		write_reg(REG_END, 8'h03);
	endtask

	task automatic test_midframe_write();
		logic [BYTE_W-1:0] chk;
		settle();
		send_byte(cfg_start);
		send_byte(8'hC3);
		settle();
		// checksum seed takes the start byte in force at the length beat
		write_reg(REG_START, 8'h41);
		chk = 8'h41 ^ 8'hC3 ^ 8'h02 ^ 8'h80 ^ 8'h01;
		send_byte(8'h02);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(chk);
		settle();
		write_reg(REG_END, 8'h99);
		send_byte(8'h99);
		settle();
		write_reg(REG_START, 8'h02);
		write_reg(REG_END, 8'h03);
	endtask

	task automatic test_random_traffic();
		int base;
		int r;
		int len;
		bit resync;
		base = bytes_taken;
		for (int seg = 0; seg < 4; seg++) begin
			settle();
			if (seg == 3)
				calm = 1'b1;
			write_reg(REG_START, 8'($urandom));
			write_reg(REG_END, 8'($urandom));
			resync = 1'b0;
			while (bytes_taken - base < (seg + 1) * 10 || (seg == 3 && beats_seen < 60)) begin
				r = $urandom_range(0, 99);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD)
					: $urandom_range(0, 6);
				if (r < 65) begin
					send_frame(8'($urandom), len, -1, FLAW_NONE, !resync);
					resync = 1'b0;
				end else if (r < 72) begin
					send_frame(8'($urandom), len, -1, FLAW_CHECK, !resync);
					resync = 1'b0;
				end else if (r < 77) begin
					send_frame(8'($urandom), len, -1, FLAW_END, !resync);
					resync = 1'b0;
				end else if (r < 81) begin
					send_frame(8'($urandom), len, -1, FLAW_CHECK_RESYNC, !resync);
					resync = 1'b1;
				end else if (r < 85) begin
					send_frame(8'($urandom), len, -1, FLAW_END_RESYNC, !resync);
					resync = 1'b1;
				end else if (r < 90) begin
					send_frame(8'($urandom), $urandom_range(MAX_PAYLOAD + 1, 255), -1,
						FLAW_NONE, !resync);
					resync = 1'b0;
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
					resync = 1'b0;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_registers();
		test_frame_shapes();
		test_bad_frames();
		test_register_extremes();
		test_midframe_write();
		test_random_traffic();

		calm = 1'b1;
		for (int n = 0; n < 20000 && pending_beats.size() != 0; n++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d payload beats never arrived", pending_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
